// ===== hw/rtl/dic_pkg.sv =====
`default_nettype none
package dic_pkg;
    localparam int STATES  = 1024;
    localparam int SYMBOLS = 26;
    localparam int ST_W    = $clog2(STATES);
    localparam int SYM_W   = 5;
    localparam int SP_W    = ST_W + 1;
    localparam int ROW_W   = SYMBOLS + 2;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_TRANS  = 2'd1;
    localparam logic [1:0] CMD_ACCEPT = 2'd2;
    localparam logic [1:0] CMD_CHECK  = 2'd3;

    typedef logic [ST_W-1:0] t_state;
endpackage
`default_nettype wire

// ===== hw/rtl/dfa_isomorphism_check_unit.sv =====
`default_nettype none
// Loads two automata one request at a time and checks them for isomorphism
// on a check request. Transition and accepting requests each update a
// per-state row in memory by read and write back; a transition request with
// a symbol out of range is dropped. A clear request, and reset, start a sweep
// over the per-state memories during which no request is taken. A check
// request first clears the visited store and then reads the start pair. For
// each reached state pair it then pops the stack and reads both rows, steps
// over each symbol that its A state does not use, and reads and checks the
// targets of each symbol that it does use. It ends when it finds the stack
// empty or finds a mismatch.
module dfa_isomorphism_check_unit (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [1:0]              i_cmd,
    input  wire logic                    i_which_automaton,
    input  wire dic_pkg::t_state         i_from_state,
    input  wire dic_pkg::t_state         i_to_state,
    input  wire logic [dic_pkg::SYM_W-1:0] i_symbol,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic                         o_is_isomorphic
);
    import dic_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RMW  = 4'd2;
    localparam logic [3:0] S_VCLR = 4'd3;
    localparam logic [3:0] S_CK1  = 4'd4;
    localparam logic [3:0] S_POP  = 4'd5;
    localparam logic [3:0] S_POPW = 4'd6;
    localparam logic [3:0] S_XRD  = 4'd7;
    localparam logic [3:0] S_SYM  = 4'd8;
    localparam logic [3:0] S_TRD  = 4'd9;
    localparam logic [3:0] S_EVAL = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(SYMBOLS - 1);
    localparam logic [ROW_W-1:0] ROW_INIT = ROW_W'(1);
    localparam t_state ONE_ST = ST_W'(1);

    // Row layout: used symbols, accepting, dead.
    logic [ROW_W-1:0]      mem_a [STATES];
    logic [ROW_W-1:0]      mem_b [STATES];
    logic [ST_W:0]         mem_v [STATES];
    logic [2*ST_W-1:0]     mem_s [STATES];
    logic [ST_W-1:0]       mem_ta [STATES*32];
    logic [ST_W-1:0]       mem_tb [STATES*32];

    logic [3:0]            r_state, n_state;
    t_state                r_cnt;
    logic [SP_W-1:0]       r_sp;
    logic [SYM_W-1:0]      r_c;
    t_state                r_x, r_y, r_qx, r_qy;
    logic [SYMBOLS-1:0]    r_used_a, r_used_b;
    logic                  r_res;
    logic [1:0]            r_cmd;
    logic                  r_which;
    t_state                r_from, r_to;
    logic [SYM_W-1:0]      r_sym;

    logic [ROW_W-1:0]      rd_a, rd_b;
    logic [ST_W:0]         rd_v;
    logic [2*ST_W-1:0]     rd_s;
    t_state                rd_ta, rd_tb;

    t_state                addr_a, addr_b, addr_v;
    logic                  we_a, we_b, we_v, we_s, we_t;
    logic [ROW_W-1:0]      wd_a, wd_b;
    t_state                wa_ab;
    logic [ST_W:0]         wd_v;
    logic [2*ST_W-1:0]     wd_s;
    t_state                wa_s;
    logic [ST_W+4:0]       ta_addr, tb_addr, tw_addr;
    logic                  accept, sym_ok;
    t_state                qy;
    logic [ROW_W-1:0]      row_upd;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_is_isomorphic = r_res;
    assign sym_ok  = (i_symbol < SYM_W'(SYMBOLS));
    assign qy      = r_used_b[r_c] ? rd_tb : '0;
    assign tw_addr = {i_from_state, i_symbol};

    always_comb begin
        row_upd = (r_which ? rd_b : rd_a);
        if (r_cmd == CMD_TRANS) begin
            row_upd[r_sym + SYM_W'(2)] = 1'b1;
            if (r_from != r_to) begin
                row_upd[0] = 1'b0;
            end
        end else begin
            row_upd[1] = 1'b1;
        end
    end

    always_comb begin
        addr_a = i_from_state;
        addr_b = i_from_state;
        addr_v = r_qx;
        ta_addr = {r_x, r_c};
        tb_addr = {r_y, r_c};
        we_a = 1'b0;
        we_b = 1'b0;
        we_v = 1'b0;
        we_s = 1'b0;
        we_t = 1'b0;
        wd_a = ROW_INIT;
        wd_b = ROW_INIT;
        wa_ab = r_cnt;
        wd_v = '0;
        wa_s = r_sp[ST_W-1:0];
        wd_s = {r_qy, r_qx};
        unique case (r_state)
            S_CLR: begin
                we_a = 1'b1;
                we_b = 1'b1;
                we_v = 1'b1;
                addr_v = r_cnt;
            end
            S_IDLE: begin
                we_t = accept && (i_cmd == CMD_TRANS) && sym_ok;
            end
            S_RMW: begin
                wa_ab = r_from;
                wd_a = row_upd;
                wd_b = row_upd;
                we_a = !r_which;
                we_b = r_which;
            end
            S_VCLR, S_CK1: begin
                addr_a = ONE_ST;
                addr_b = ONE_ST;
                addr_v = (r_state == S_VCLR) ? r_cnt : ONE_ST;
                we_v = (r_state == S_VCLR) || (rd_a[1] == rd_b[1]);
                wd_v = (r_state == S_VCLR) ? '0 : {1'b1, ONE_ST};
                we_s = (r_state == S_CK1) && (rd_a[1] == rd_b[1]);
                wa_s = '0;
                wd_s = {ONE_ST, ONE_ST};
            end
            S_POPW: begin
                addr_a = rd_s[ST_W-1:0];
                addr_b = rd_s[2*ST_W-1:ST_W];
            end
            S_TRD: begin
                addr_a = rd_ta;
                addr_b = qy;
                addr_v = rd_ta;
            end
            S_EVAL: begin
                if ((rd_a[0] == rd_b[0]) && !rd_v[ST_W] && (rd_a[1] == rd_b[1])) begin
                    we_v = 1'b1;
                    wd_v = {1'b1, r_qy};
                    we_s = (r_sp < SP_W'(STATES));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            mem_a[wa_ab] <= wd_a;
        end
        if (we_b) begin
            mem_b[wa_ab] <= wd_b;
        end
        if (we_v) begin
            mem_v[addr_v] <= wd_v;
        end
        if (we_s) begin
            mem_s[wa_s] <= wd_s;
        end
        if (we_t && !i_which_automaton) begin
            mem_ta[tw_addr] <= i_to_state;
        end
        if (we_t && i_which_automaton) begin
            mem_tb[tw_addr] <= i_to_state;
        end
        rd_a  <= mem_a[addr_a];
        rd_b  <= mem_b[addr_b];
        rd_v  <= mem_v[addr_v];
        rd_s  <= mem_s[r_sp[ST_W-1:0] - ST_W'(1)];
        rd_ta <= mem_ta[ta_addr];
        rd_tb <= mem_tb[tb_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_cnt == t_state'(STATES - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        CMD_CLEAR:  n_state = S_CLR;
                        CMD_TRANS:  n_state = sym_ok ? S_RMW : S_IDLE;
                        CMD_ACCEPT: n_state = S_RMW;
                        CMD_CHECK:  n_state = S_VCLR;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_RMW:  n_state = S_IDLE;
            S_VCLR: if (r_cnt == t_state'(STATES - 1)) n_state = S_CK1;
            S_CK1:  n_state = (rd_a[1] == rd_b[1]) ? S_POP : S_OUT;
            S_POP:  n_state = (r_sp == '0) ? S_OUT : S_POPW;
            S_POPW: n_state = S_XRD;
            S_XRD:  n_state = S_SYM;
            S_SYM: begin
                if (r_used_a[r_c]) n_state = S_TRD;
                else if (r_c == LAST_SYM) n_state = S_POP;
            end
            S_TRD:  n_state = S_EVAL;
            S_EVAL: begin
                if ((rd_a[0] != rd_b[0])
                    || (rd_v[ST_W] && (rd_v[ST_W-1:0] != r_qy))
                    || (!rd_v[ST_W] && (rd_a[1] != rd_b[1]))) begin
                    n_state = S_OUT;
                end else begin
                    n_state = (r_c == LAST_SYM) ? S_POP : S_SYM;
                end
            end
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_sp    <= '0;
            r_c     <= '0;
            r_res   <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_CLR) || (r_state == S_VCLR)) begin
                r_cnt <= r_cnt + ST_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (r_state == S_CK1) begin
                r_sp  <= SP_W'(1);
                r_res <= 1'b0;
            end
            if ((r_state == S_POP) && (r_sp != '0)) begin
                r_sp <= r_sp - SP_W'(1);
            end
            if ((r_state == S_POP) && (r_sp == '0)) begin
                r_res <= 1'b1;
            end
            if (we_s && (r_state == S_EVAL)) begin
                r_sp <= r_sp + SP_W'(1);
            end
            if (r_state == S_XRD) begin
                r_c <= '0;
            end
            if (((r_state == S_SYM) && !r_used_a[r_c]) || (r_state == S_EVAL)) begin
                r_c <= r_c + SYM_W'(1);
            end
            if (n_state == S_OUT && r_state == S_EVAL) begin
                r_res <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_which <= i_which_automaton;
            r_from  <= i_from_state;
            r_to    <= i_to_state;
            r_sym   <= i_symbol;
        end
        if (r_state == S_POPW) begin
            r_x <= rd_s[ST_W-1:0];
            r_y <= rd_s[2*ST_W-1:ST_W];
        end
        if (r_state == S_XRD) begin
            r_used_a <= rd_a[ROW_W-1:2];
            r_used_b <= rd_b[ROW_W-1:2];
        end
        if (r_state == S_TRD) begin
            r_qx <= rd_ta;
            r_qy <= qy;
        end
    end
endmodule
`default_nettype wire
